### hw/rtl/two_set_membership_engine_assert.svh
`ifndef TWO_SET_MEMBERSHIP_ENGINE_ASSERT_SVH
`define TWO_SET_MEMBERSHIP_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TSME_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsme check failed");

// next-cycle implication, sampled on clk, off during rst
`define TSME_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsme check failed");

`endif

### hw/rtl/tsme_pkg.sv
package tsme_pkg;

  localparam int SET_CAPACITY_DEF = 32;
  localparam int ELEMENT_BITS_DEF = 32;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_QUERY  = 3'd1,
    MODE_COUNT  = 3'd2,
    MODE_SUBSET = 3'd3,
    MODE_UNION  = 3'd4,
    MODE_INTER  = 3'd5,
    MODE_DIFF   = 3'd6,
    MODE_CLEAR  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_PRESENT = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH,
    S_LOAD,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic hit_capture;
    logic fetch;
    logic flip;
    logic key_load;
    logic pend_push;
    logic emit_mid;
    logic resp;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  phase;
    logic  scan_done;
    logic  hit;
    logic  outer_more;
    logic  take;
    logic  pend_have;
    logic  oreg_free;
  } stat_t;

endpackage

### hw/rtl/tsme_ctrl.sv
module tsme_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsme_pkg::stat_t st,
  output tsme_pkg::cmd_t  cmd
);

  tsme_pkg::state_t state;
  tsme_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsme_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tsme_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = tsme_pkg::S_DISPATCH;
        end
      end
      tsme_pkg::S_DISPATCH: begin
        unique case (st.mode)
          tsme_pkg::MODE_INSERT, tsme_pkg::MODE_QUERY: state_next = tsme_pkg::S_SCAN;
          tsme_pkg::MODE_COUNT, tsme_pkg::MODE_CLEAR:  state_next = tsme_pkg::S_RESP;
          tsme_pkg::MODE_SUBSET, tsme_pkg::MODE_UNION,
          tsme_pkg::MODE_INTER, tsme_pkg::MODE_DIFF:   state_next = tsme_pkg::S_FETCH;
        endcase
      end
      tsme_pkg::S_FETCH: begin
        priority if (st.outer_more) begin
          cmd.fetch  = 1'b1;
          state_next = tsme_pkg::S_LOAD;
        end else if (st.mode == tsme_pkg::MODE_UNION && !st.phase) begin
          cmd.flip = 1'b1;
        end else begin
          state_next = tsme_pkg::S_RESP;
        end
      end
      tsme_pkg::S_LOAD: begin
        cmd.key_load = 1'b1;
        state_next   = tsme_pkg::S_SCAN;
      end
      tsme_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          cmd.hit_capture = 1'b1;
          unique case (st.mode)
            tsme_pkg::MODE_INSERT, tsme_pkg::MODE_QUERY: state_next = tsme_pkg::S_RESP;
            tsme_pkg::MODE_SUBSET:
              state_next = st.hit ? tsme_pkg::S_FETCH : tsme_pkg::S_RESP;
            default: state_next = tsme_pkg::S_DECIDE;
          endcase
        end
      end
      tsme_pkg::S_DECIDE: begin
        priority if (!st.take) begin
          state_next = tsme_pkg::S_FETCH;
        end else if (!st.pend_have) begin
          cmd.pend_push = 1'b1;
          state_next    = tsme_pkg::S_FETCH;
        end else if (st.oreg_free) begin
          cmd.emit_mid  = 1'b1;
          cmd.pend_push = 1'b1;
          state_next    = tsme_pkg::S_FETCH;
        end else begin
          state_next = tsme_pkg::S_DECIDE;
        end
      end
      tsme_pkg::S_RESP: begin
        if (st.oreg_free) begin
          cmd.resp   = 1'b1;
          state_next = tsme_pkg::S_IDLE;
        end
      end
      default: state_next = tsme_pkg::S_IDLE;
    endcase
  end

endmodule

### hw/rtl/tsme_dp.sv
module tsme_dp #(
  parameter int SET_CAPACITY = tsme_pkg::SET_CAPACITY_DEF,
  parameter int ELEMENT_BITS = tsme_pkg::ELEMENT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tsme_pkg::cmd_t      cmd,
  output tsme_pkg::stat_t     st,
  input  logic [2:0]          mode,
  input  logic                set_select,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic                found,
  output logic [5:0]          set_count,
  output logic signed [31:0]  element,
  output logic                element_valid,
  output logic                last
);

  localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam int VW = (ELEMENT_BITS < 32) ? ELEMENT_BITS : 32;

  logic [VW-1:0] mem_a [SET_CAPACITY];
  logic [VW-1:0] mem_b [SET_CAPACITY];
  logic [VW-1:0] rd_a;
  logic [VW-1:0] rd_b;

  tsme_pkg::mode_t mode_r;
  logic            sel;
  logic            phase;
  logic [VW-1:0]   key;
  logic [CW-1:0]   i;
  logic [CW-1:0]   j;
  logic            scan_pend;
  logic            hit_flag;
  logic            pend_have;
  logic [VW-1:0]   pend_elem;
  logic [CW-1:0]   count_a;
  logic [CW-1:0]   count_b;

  logic [CW-1:0]   n1;
  logic [CW-1:0]   n2;
  logic [CW-1:0]   n_inner;
  logic [CW-1:0]   n_outer;
  logic [CW-1:0]   n1_inc;
  logic            inner_is_b;
  logic [VW-1:0]   rd_inner;
  logic [VW-1:0]   rd_outer;
  logic            issue;
  logic            hit;
  logic            full;
  logic            ins_ok;
  logic            take;
  logic            oreg_free;
  logic [AW-1:0]   addr_a;
  logic [AW-1:0]   addr_b;
  logic            wr_a;
  logic            wr_b;
  tsme_pkg::mode_t mode_in;

  assign mode_in    = tsme_pkg::mode_t'(mode);
  assign n1         = sel ? count_b : count_a;
  assign n2         = sel ? count_a : count_b;
  assign n1_inc     = n1 + CW'(1);
  assign inner_is_b = ~(phase ^ sel);
  assign n_inner    = phase ? n1 : n2;
  assign n_outer    = phase ? n2 : n1;
  assign rd_inner   = inner_is_b ? rd_b : rd_a;
  assign rd_outer   = inner_is_b ? rd_a : rd_b;
  assign issue      = j < n_inner;
  assign hit        = scan_pend && (rd_inner == key);
  assign full       = n1 >= CW'(SET_CAPACITY);
  assign ins_ok     = (mode_r == tsme_pkg::MODE_INSERT) && !hit_flag && !full;
  assign oreg_free  = !out_valid || out_ready;
  assign take       = phase ? !hit_flag :
                      (mode_r == tsme_pkg::MODE_UNION) ||
                      ((mode_r == tsme_pkg::MODE_INTER) && hit_flag) ||
                      ((mode_r == tsme_pkg::MODE_DIFF) && !hit_flag);

  assign addr_a = inner_is_b ? i[AW-1:0] : j[AW-1:0];
  assign addr_b = inner_is_b ? j[AW-1:0] : i[AW-1:0];
  assign wr_a   = cmd.resp && ins_ok && !sel;
  assign wr_b   = cmd.resp && ins_ok && sel;

  always_comb begin
    st.mode       = mode_r;
    st.phase      = phase;
    st.scan_done  = hit || (!scan_pend && !issue);
    st.hit        = hit;
    st.outer_more = i < n_outer;
    st.take       = take;
    st.pend_have  = pend_have;
    st.oreg_free  = oreg_free;
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[n1[AW-1:0]] <= key;
    end
    rd_a <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[n1[AW-1:0]] <= key;
    end
    rd_b <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r    <= mode_in;
      sel       <= set_select;
      phase     <= (mode_in == tsme_pkg::MODE_INSERT) || (mode_in == tsme_pkg::MODE_QUERY);
      key       <= value[VW-1:0];
      i         <= '0;
      j         <= '0;
      scan_pend <= 1'b0;
      hit_flag  <= 1'b1;
    end
    if (cmd.scan_step) begin
      if (issue) begin
        j <= j + CW'(1);
      end
      scan_pend <= issue;
    end
    if (cmd.hit_capture) begin
      hit_flag <= hit;
    end
    if (cmd.fetch) begin
      i <= i + CW'(1);
    end
    if (cmd.flip) begin
      phase <= 1'b1;
      i     <= '0;
    end
    if (cmd.key_load) begin
      key       <= rd_outer;
      j         <= '0;
      scan_pend <= 1'b0;
    end
    if (cmd.pend_push) begin
      pend_elem <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_have <= 1'b0;
      count_a   <= '0;
      count_b   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pend_have <= 1'b0;
      end else if (cmd.pend_push) begin
        pend_have <= 1'b1;
      end
      if (cmd.resp && ins_ok) begin
        if (sel) begin
          count_b <= n1_inc;
        end else begin
          count_a <= n1_inc;
        end
      end
      if (cmd.resp && mode_r == tsme_pkg::MODE_CLEAR) begin
        if (sel) begin
          count_b <= '0;
        end else begin
          count_a <= '0;
        end
      end
      if (cmd.emit_mid || cmd.resp) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid) begin
      status        <= tsme_pkg::STATUS_OK;
      found         <= 1'b0;
      set_count     <= 6'(n1);
      element       <= 32'(pend_elem);
      element_valid <= 1'b1;
      last          <= 1'b0;
    end else if (cmd.resp) begin
      priority if (mode_r != tsme_pkg::MODE_INSERT) begin
        status <= tsme_pkg::STATUS_OK;
      end else if (hit_flag) begin
        status <= tsme_pkg::STATUS_PRESENT;
      end else if (full) begin
        status <= tsme_pkg::STATUS_FULL;
      end else begin
        status <= tsme_pkg::STATUS_OK;
      end
      found <= hit_flag && ((mode_r == tsme_pkg::MODE_INSERT) ||
                            (mode_r == tsme_pkg::MODE_QUERY) ||
                            (mode_r == tsme_pkg::MODE_SUBSET));
      priority if (mode_r == tsme_pkg::MODE_CLEAR) begin
        set_count <= '0;
      end else if (ins_ok) begin
        set_count <= 6'(n1_inc);
      end else begin
        set_count <= 6'(n1);
      end
      element       <= pend_have ? 32'(pend_elem) : '0;
      element_valid <= pend_have;
      last          <= 1'b1;
    end
  end

endmodule

### hw/rtl/two_set_membership_engine.sv
// channel | handshake           | payload
// --------+---------------------+-----------------------------------------------
// request | in_valid, in_ready  | mode, set_select, value
// result  | out_valid,out_ready | status, found, set_count, element,
//         |                     | element_valid, last
//
// Count and clear need no scan; insert and query scan the selected set linearly.
// Subset and set operations fetch each outer element and scan the other
// set linearly for it, in both directions for a union;
// the single read port of each store sets this pace.
// Reset clears both counts; store contents are not cleared and need no sweep.
// A result waits in the output register while the next request is taken; the
// core holds only when it must load a result and that register is still full.
module two_set_membership_engine #(
  parameter int SET_CAPACITY = tsme_pkg::SET_CAPACITY_DEF,
  parameter int ELEMENT_BITS = tsme_pkg::ELEMENT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic               set_select,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               found,
  output logic [5:0]         set_count,
  output logic signed [31:0] element,
  output logic               element_valid,
  output logic               last
);

  tsme_pkg::cmd_t  cmd;
  tsme_pkg::stat_t st;

  tsme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tsme_dp #(
    .SET_CAPACITY (SET_CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .mode          (mode),
    .set_select    (set_select),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found         (found),
    .set_count     (set_count),
    .element       (element),
    .element_valid (element_valid),
    .last          (last)
  );

endmodule

### hw/rtl/tsme_checker.sv
`include "two_set_membership_engine_assert.svh"

module tsme_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic               found,
  input logic [5:0]         set_count,
  input logic signed [31:0] element,
  input logic               element_valid,
  input logic               last
);

  logic [42:0] payload;

  assign payload = {status, found, set_count, element, element_valid, last};

  `TSME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload))
  `TSME_ASSERT_IMPL(a_member_clean, out_valid && element_valid, status == tsme_pkg::STATUS_OK && !found)
  `TSME_ASSERT_IMPL(a_single_last, out_valid && !element_valid, last)
  `TSME_ASSERT_IMPL(a_full_miss, out_valid && status == tsme_pkg::STATUS_FULL, !found && last && !element_valid)

endmodule

bind two_set_membership_engine tsme_checker u_tsme_checker (.*);
